### rtl/dsc_pkg.sv
package dsc_pkg;

	localparam int WIDTH_DEF = 32;
	localparam int COUNT_W   = 33;
	localparam int STATUS_W  = 2;

	localparam logic [STATUS_W-1:0] ST_COUNTED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOSOL   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

	// division jobs, in the order the controller walks them
	typedef enum logic [3:0] {
		J_EUC, J_C, J_A, J_B, J_SA, J_CP, J_X, J_Y, J_LO, J_HI, J_L2, J_H2
	} job_t;

	typedef struct packed {
		logic load;
		logic init;
		logic div_start;
		logic div_take;
		logic mul;
		logic upd;
		logic fin;
		logic invalid;
		job_t job;
	} dsc_cmd_t;

	typedef struct packed {
		logic zero_coef;
		logic r1_zero;
		logic div_done;
		logic rem_nz;
	} dsc_sts_t;

endpackage

### rtl/dsc_div.sv
module dsc_div #(
	parameter int DW = 68
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [DW-1:0] dividend,
	input  logic signed [DW-1:0] divisor,
	output logic                 done,
	output logic signed [DW-1:0] quo,
	output logic signed [DW-1:0] rem
);

	localparam int CW = $clog2(DW + 1);

	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q, qneg_q, rneg_q;
	logic [DW-1:0] quo_q, dvs_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] dd_mag, ds_mag;
	logic [DW:0]   rem_sh, trial;
	logic          ge;

	// truncating signed division, restoring, one quotient bit per cycle
	assign dd_mag = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
	assign ds_mag = divisor[DW-1] ? DW'(-divisor) : DW'(divisor);
	assign rem_sh = {rem_q[DW-1:0], quo_q[DW-1]};
	assign trial  = rem_sh - {1'b0, dvs_q};
	assign ge     = !trial[DW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dd_mag;
			dvs_q  <= ds_mag;
			qneg_q <= dividend[DW-1] ^ divisor[DW-1];
			rneg_q <= dividend[DW-1];
		end else if (busy_q) begin
			rem_q <= ge ? trial : rem_sh;
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = qneg_q ? -$signed(quo_q) : $signed(quo_q);
	assign rem  = rneg_q ? -$signed(rem_q[DW-1:0]) : $signed(rem_q[DW-1:0]);

endmodule

### rtl/dsc_dp.sv
module dsc_dp #(
	parameter int WIDTH = 32,
	parameter int MW    = WIDTH + 2,
	parameter int DW    = 2 * MW
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [WIDTH-1:0]       coef_a,
	input  logic signed [WIDTH-1:0]       coef_b,
	input  logic signed [WIDTH-1:0]       rhs_c,
	input  logic signed [WIDTH-1:0]       x_low,
	input  logic signed [WIDTH-1:0]       x_high,
	input  logic signed [WIDTH-1:0]       y_low,
	input  logic signed [WIDTH-1:0]       y_high,
	input  dsc_pkg::dsc_cmd_t             cmd,
	output dsc_pkg::dsc_sts_t             sts,
	output logic [dsc_pkg::COUNT_W-1:0]   solution_count,
	output logic [dsc_pkg::STATUS_W-1:0]  status
);

	import dsc_pkg::*;

	logic signed [WIDTH-1:0] a_q, b_q, c_q, xl_q, xh_q, yl_q, yh_q;
	logic signed [DW-1:0] r0_q, r1_q, s0_q, s1_q, kq_q, prod_q, cp_q, ap_q, bp_q, bb_q;
	logic signed [DW-1:0] ms_q, mc_q, xv_q, yv_q, lo_q, hi_q, l2_q, h2_q;
	logic [COUNT_W-1:0]  count_q;
	logic [STATUS_W-1:0] status_q;

	logic signed [DW-1:0] ae, be, ce, xle, xhe, yle, yhe;
	logic signed [DW-1:0] sa, dd, n1, n2, dvd, dvs, dq, dr, fmod, floorv, ceilv;
	logic signed [DW-1:0] lo_m, hi_m, diff;
	logic signed [MW-1:0] ma, mb;
	logic signed [DW-1:0] mul_full;
	logic                 a_pos, dv_done;

	assign ae  = DW'(a_q);
	assign be  = DW'(b_q);
	assign ce  = DW'(c_q);
	assign xle = DW'(xl_q);
	assign xhe = DW'(xh_q);
	assign yle = DW'(yl_q);
	assign yhe = DW'(yh_q);

	// Bezout coefficient of a with the sign of a folded in
	assign sa    = a_q[WIDTH-1] ? -s0_q : s0_q;
	// slope of y in t is -A; A > 0 when ap and bp carry the same sign
	assign a_pos = !ap_q[DW-1] ^ bp_q[DW-1];
	assign dd    = ap_q[DW-1] ? -ap_q : ap_q;
	assign n1    = a_pos ? yv_q - yhe : yle - yv_q;
	assign n2    = a_pos ? yv_q - yle : yhe - yv_q;

	always_comb begin
		dvd = r0_q;
		dvs = r1_q;
		case (cmd.job)
			J_EUC: begin dvd = r0_q;          dvs = r1_q; end
			J_C:   begin dvd = ce;            dvs = r0_q; end
			J_A:   begin dvd = ae;            dvs = r0_q; end
			J_B:   begin dvd = be;            dvs = r0_q; end
			J_SA:  begin dvd = sa;            dvs = bb_q; end
			J_CP:  begin dvd = cp_q;          dvs = bb_q; end
			J_X:   begin dvd = prod_q;        dvs = bb_q; end
			J_Y:   begin dvd = cp_q - prod_q; dvs = bp_q; end
			J_LO:  begin dvd = xle - xv_q;    dvs = bb_q; end
			J_HI:  begin dvd = xhe - xv_q;    dvs = bb_q; end
			J_L2:  begin dvd = n1;            dvs = dd;   end
			J_H2:  begin dvd = n2;            dvs = dd;   end
			default: begin dvd = r0_q;        dvs = r1_q; end
		endcase
	end

	always_comb begin
		ma = MW'(kq_q);
		mb = MW'(s1_q);
		case (cmd.job)
			J_EUC:   begin ma = MW'(kq_q); mb = MW'(s1_q); end
			J_X:     begin ma = MW'(ms_q); mb = MW'(mc_q); end
			J_Y:     begin ma = MW'(ap_q); mb = MW'(xv_q); end
			default: begin ma = MW'(kq_q); mb = MW'(s1_q); end
		endcase
	end

	assign mul_full = ma * mb;

	dsc_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (dv_done),
		.quo      (dq),
		.rem      (dr)
	);

	// divisor is positive wherever these are used
	assign fmod   = dr[DW-1] ? dr + bb_q : dr;
	assign floorv = dr[DW-1] ? dq - DW'(1) : dq;
	assign ceilv  = (dr != '0 && !dr[DW-1]) ? dq + DW'(1) : dq;

	assign lo_m = (l2_q > lo_q) ? l2_q : lo_q;
	assign hi_m = (h2_q < hi_q) ? h2_q : hi_q;
	assign diff = hi_m - lo_m + DW'(1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q  <= coef_a;
			b_q  <= coef_b;
			c_q  <= rhs_c;
			xl_q <= x_low;
			xh_q <= x_high;
			yl_q <= y_low;
			yh_q <= y_high;
		end
		if (cmd.init) begin
			r0_q <= ae[DW-1] ? -ae : ae;
			r1_q <= be[DW-1] ? -be : be;
			s0_q <= DW'(1);
			s1_q <= '0;
		end
		if (cmd.mul)
			prod_q <= mul_full;
		if (cmd.upd) begin
			s0_q <= s1_q;
			s1_q <= s0_q - prod_q;
		end
		if (cmd.div_take) begin
			case (cmd.job)
				J_EUC: begin
					r0_q <= r1_q;
					r1_q <= dr;
					kq_q <= dq;
				end
				J_C: begin
					cp_q <= dq;
					if (dr != '0) begin
						status_q <= ST_NOSOL;
						count_q  <= '0;
					end
				end
				J_A:  ap_q <= dq;
				J_B: begin
					bp_q <= dq;
					bb_q <= dq[DW-1] ? -dq : dq;
				end
				J_SA: ms_q <= fmod;
				J_CP: mc_q <= fmod;
				J_X:  xv_q <= dr;
				J_Y:  yv_q <= dq;
				J_LO: lo_q <= ceilv;
				J_HI: hi_q <= floorv;
				J_L2: l2_q <= ceilv;
				J_H2: h2_q <= floorv;
				default: ;
			endcase
		end
		if (cmd.invalid) begin
			status_q <= ST_INVALID;
			count_q  <= '0;
		end
		if (cmd.fin) begin
			status_q <= ST_COUNTED;
			count_q  <= (hi_m >= lo_m) ? COUNT_W'(diff) : '0;
		end
	end

	assign sts.zero_coef = (a_q == '0) || (b_q == '0);
	assign sts.r1_zero   = (r1_q == '0);
	assign sts.div_done  = dv_done;
	assign sts.rem_nz    = (dr != '0);

	assign solution_count = count_q;
	assign status         = status_q;

endmodule

### rtl/dsc_ctrl.sv
module dsc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  dsc_pkg::dsc_sts_t sts,
	output dsc_pkg::dsc_cmd_t cmd
);

	import dsc_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_ZCHK   = 9'b000000010,
		S_ETST   = 9'b000000100,
		S_DSTART = 9'b000001000,
		S_DWAIT  = 9'b000010000,
		S_MUL    = 9'b000100000,
		S_UPD    = 9'b001000000,
		S_FIN    = 9'b010000000,
		S_OUT    = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	job_t   job_q, job_d;

	always_comb begin
		cmd     = '0;
		cmd.job = job_q;
		state_d = state_q;
		job_d   = job_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_ZCHK;
				end
			end
			S_ZCHK: begin
				if (sts.zero_coef) begin
					cmd.invalid = 1'b1;
					state_d     = S_OUT;
				end else begin
					cmd.init = 1'b1;
					state_d  = S_ETST;
				end
			end
			S_ETST: begin
				job_d   = sts.r1_zero ? J_C : J_EUC;
				state_d = S_DSTART;
			end
			S_DSTART: begin
				cmd.div_start = 1'b1;
				state_d       = S_DWAIT;
			end
			S_DWAIT: begin
				if (sts.div_done) begin
					cmd.div_take = 1'b1;
					state_d      = S_DSTART;
					case (job_q)
						J_EUC: state_d = S_MUL;
						J_C: begin
							if (sts.rem_nz)
								state_d = S_OUT;
							else
								job_d = J_A;
						end
						J_A:  job_d = J_B;
						J_B:  job_d = J_SA;
						J_SA: job_d = J_CP;
						J_CP: begin
							job_d   = J_X;
							state_d = S_MUL;
						end
						J_X: begin
							job_d   = J_Y;
							state_d = S_MUL;
						end
						J_Y:  job_d = J_LO;
						J_LO: job_d = J_HI;
						J_HI: job_d = J_L2;
						J_L2: job_d = J_H2;
						J_H2: state_d = S_FIN;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = (job_q == J_EUC) ? S_UPD : S_DSTART;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_d = S_ETST;
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			job_q   <= J_EUC;
		end else begin
			state_q <= state_d;
			job_q   <= job_d;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

`ifndef ASSERT_OFF
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output open at once");

	a_take_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_take |-> sts.div_done)
		else $error("quotient taken before divider finished");

	a_start_after_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !sts.div_done)
		else $error("divider done right after start");

	a_return_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> in_ready)
		else $error("no return to idle after result transaction");
`endif

endmodule

### rtl/diophantine_solution_counter.sv
// Linear Diophantine solution counter.
// Input channel (in_valid/in_ready): one transaction carries a*x + b*y = c
// and inclusive x and y ranges, all WIDTH-bit two's complement.
// Output channel (out_valid/out_ready): one transaction per input with
// solution_count and status (0 counted, 1 no integer solution, 2 zero
// coefficient). A zero coefficient is reported before divisibility.
// One item is worked at a time; in_ready is high only while idle.
// The work is done by a shared restoring divider of D = 2*WIDTH+4 bits
// that yields one quotient bit per cycle.
// Extended Euclid runs E quotient steps (E <= ~47 at WIDTH=32), each a
// test, a division, a multiply and an update; eleven more divisions and
// two multiplies follow. A zero coefficient skips all divisions and goes
// straight to the result transaction.
// Reset (arst_n low) returns the controller to idle; no result is pending.
// If the receiver stalls, the result holds on the outputs and no new
// input transaction is taken until the result transaction completes.
module diophantine_solution_counter #(
	parameter int WIDTH = dsc_pkg::WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [WIDTH-1:0]       coef_a,
	input  logic signed [WIDTH-1:0]       coef_b,
	input  logic signed [WIDTH-1:0]       rhs_c,
	input  logic signed [WIDTH-1:0]       x_low,
	input  logic signed [WIDTH-1:0]       x_high,
	input  logic signed [WIDTH-1:0]       y_low,
	input  logic signed [WIDTH-1:0]       y_high,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dsc_pkg::COUNT_W-1:0]   solution_count,
	output logic [dsc_pkg::STATUS_W-1:0]  status
);

	import dsc_pkg::*;

	// multiplier operand width and datapath width
	localparam int MW = WIDTH + 2;
	localparam int DW = 2 * MW;

	dsc_cmd_t cmd;
	dsc_sts_t sts;

	dsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	dsc_dp #(.WIDTH(WIDTH), .MW(MW), .DW(DW)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.coef_a         (coef_a),
		.coef_b         (coef_b),
		.rhs_c          (rhs_c),
		.x_low          (x_low),
		.x_high         (x_high),
		.y_low          (y_low),
		.y_high         (y_high),
		.cmd            (cmd),
		.sts            (sts),
		.solution_count (solution_count),
		.status         (status)
	);

endmodule
